// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hsvg2rgb_pkg.sv -----
`default_nettype none

package hsvg2rgb_pkg;

  // Fixed-point format: 16-bit fractions, all ones means 1.0
  localparam int unsigned FRAC_W   = 16;
  localparam logic [15:0] UNIT_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_START_HUE = 3'd0;
  localparam logic [2:0] REG_START_SAT = 3'd1;
  localparam logic [2:0] REG_START_VAL = 3'd2;
  localparam logic [2:0] REG_END_HUE   = 3'd3;
  localparam logic [2:0] REG_END_SAT   = 3'd4;
  localparam logic [2:0] REG_END_VAL   = 3'd5;

  // Hue sectors of the six-sector scheme
  localparam logic [2:0] SEC_R_TO_Y = 3'd0;
  localparam logic [2:0] SEC_Y_TO_G = 3'd1;
  localparam logic [2:0] SEC_G_TO_C = 3'd2;
  localparam logic [2:0] SEC_C_TO_B = 3'd3;
  localparam logic [2:0] SEC_B_TO_M = 3'd4;
  localparam logic [2:0] SEC_M_TO_R = 3'd5;

  // One RGB result
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Divide by 2^16-1 for a dividend of at most (2^16-1)^2.
  // n = hi*2^16 + lo = hi*M + (hi + lo), and hi + lo stays below 2*M + 1,
  // so two compares fix up the quotient.
  function automatic logic [15:0] div_unit_max(input logic [31:0] n);
    logic [16:0] rem;
    logic [16:0] quo;
    rem = {1'b0, n[15:0]} + {1'b0, n[31:16]};
    quo = {1'b0, n[31:16]}
        + ((rem >= {1'b0, UNIT_MAX}) ? 17'd1 : 17'd0)
        + ((rem >= {UNIT_MAX, 1'b0}) ? 17'd1 : 17'd0);
    return quo[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hsv_gradient_to_rgb_core.sv -----
`default_nettype none
`include "assert_macros.svh"

// HSV to 8-bit RGB converter, six-sector scheme. Each input beat either
// carries an HSV color (tuser = 0) or a gradient position (tuser = 1) that
// is first blended between the start and end colors held in the
// configuration registers. Every beat gives exactly one RGB beat. The block
// is a 9-stage pipeline: a beat accepted into stage 1 passes through each
// stage register in turn to the output register, and one beat can enter
// every cycle unless backpressure holds a full pipeline. The depth is set by
// the chain of three registered multiplies (blend, sector scaling, value
// scaling), with divide-by-65535 fixups after the blend and value. Backpressure
// stalls only the stages that are full, so bubbles are squeezed out while
// the output waits. Write the configuration only while no beat is in flight.
module hsv_gradient_to_rgb_core
  import hsvg2rgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // hue, saturation, brightness, position
  input  wire logic        in_tuser,   // operation
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // red, green, blue
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned NSTG = 9;

  // configuration registers
  logic [15:0] start_hue_r, start_sat_r, start_val_r;
  logic [15:0] end_hue_r, end_sat_r, end_val_r;

  // pipeline control
  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] en;
  logic            mid_stall;

  // input fields
  logic [15:0] in_hue, in_sat, in_bri, in_pos;

  // stage 1: blend products
  logic        op1_r;
  logic [15:0] hue1_r, sat1_r, bri1_r;
  logic [31:0] ha1_r, hb1_r, sa1_r, sb1_r, va1_r, vb1_r;
  // stage 2: blend sums
  logic        op2_r;
  logic [15:0] hue2_r, sat2_r, bri2_r;
  logic [31:0] hn2_r, sn2_r, vn2_r;
  // stage 3: HSV
  logic [15:0] h3_r, s3_r, v3_r;
  // stage 4: sector split
  logic [18:0] hx6;
  logic [2:0]  sec4_r;
  logic [15:0] f4_r, s4_r, v4_r;
  logic [16:0] g4_r;
  // stage 5: saturation scaling
  logic [2:0]  sec5_r;
  logic [15:0] sf5_r, sg5_r, v5_r;
  logic [31:0] pp5_r;
  logic [31:0] sf_prod;
  logic [32:0] sg_prod;
  // stage 6: value products
  logic [2:0]  sec6_r;
  logic [15:0] v6_r;
  logic [31:0] pp6_r, qp6_r, rp6_r;
  // stage 7: p, q, r
  logic [2:0]  sec7_r;
  logic [15:0] v7_r, p7_r, q7_r, r7_r;
  // stage 8: channels times 255
  logic [15:0] cr, cg, cb;
  logic [23:0] rx8_r, gx8_r, bx8_r;
  // stage 9: output
  rgb_t        rgb9_r;

  assign in_hue = in_tdata[15:0];
  assign in_sat = in_tdata[31:16];
  assign in_bri = in_tdata[47:32];
  assign in_pos = in_tdata[63:48];

  // Write configuration registers, drop indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hue_r <= '0;
      start_sat_r <= '0;
      start_val_r <= '0;
      end_hue_r   <= '0;
      end_sat_r   <= '0;
      end_val_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_HUE: start_hue_r <= cfg_wdata;
        REG_START_SAT: start_sat_r <= cfg_wdata;
        REG_START_VAL: start_val_r <= cfg_wdata;
        REG_END_HUE:   end_hue_r   <= cfg_wdata;
        REG_END_SAT:   end_sat_r   <= cfg_wdata;
        REG_END_VAL:   end_val_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances
  always_comb begin
    en[NSTG+1] = out_tready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = rgb9_r;

  // Move valid bits along with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: weight start and end points by (1 - t) and t
  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1_r  <= in_tuser;
      hue1_r <= in_hue;
      sat1_r <= in_sat;
      bri1_r <= in_bri;
      ha1_r  <= (UNIT_MAX - in_pos) * start_hue_r;
      hb1_r  <= in_pos * end_hue_r;
      sa1_r  <= (UNIT_MAX - in_pos) * start_sat_r;
      sb1_r  <= in_pos * end_sat_r;
      va1_r  <= (UNIT_MAX - in_pos) * start_val_r;
      vb1_r  <= in_pos * end_val_r;
    end
  end

  // Stage 2: sum the weighted terms, at most (2^16-1)^2 each
  always_ff @(posedge clk) begin
    if (en[2]) begin
      op2_r  <= op1_r;
      hue2_r <= hue1_r;
      sat2_r <= sat1_r;
      bri2_r <= bri1_r;
      hn2_r  <= ha1_r + hb1_r;
      sn2_r  <= sa1_r + sb1_r;
      vn2_r  <= va1_r + vb1_r;
    end
  end

  // Stage 3: finish the blend or take the direct color
  always_ff @(posedge clk) begin
    if (en[3]) begin
      h3_r <= op2_r ? div_unit_max(hn2_r) : hue2_r;
      s3_r <= op2_r ? div_unit_max(sn2_r) : sat2_r;
      v3_r <= op2_r ? div_unit_max(vn2_r) : bri2_r;
    end
  end

  // Stage 4: hue times six gives sector and fraction within it
  assign hx6 = {1'b0, h3_r, 2'b00} + {2'b00, h3_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sec4_r <= hx6[18:16];
      f4_r   <= hx6[15:0];
      g4_r   <= 17'h10000 - {1'b0, hx6[15:0]};
      s4_r   <= s3_r;
      v4_r   <= v3_r;
    end
  end

  // Stage 5: scale saturation by the fraction and its complement
  assign sf_prod = s4_r * f4_r;
  assign sg_prod = s4_r * g4_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sec5_r <= sec4_r;
      v5_r   <= v4_r;
      sf5_r  <= sf_prod[31:16];
      // complement is at most 2^16, so the shifted product stays within s
      sg5_r  <= sg_prod[31:16];
      pp5_r  <= v4_r * (UNIT_MAX - s4_r);
    end
  end

  // Stage 6: value products for q and r
  always_ff @(posedge clk) begin
    if (en[6]) begin
      sec6_r <= sec5_r;
      v6_r   <= v5_r;
      pp6_r  <= pp5_r;
      qp6_r  <= v5_r * (UNIT_MAX - sf5_r);
      rp6_r  <= v5_r * (UNIT_MAX - sg5_r);
    end
  end

  // Stage 7: normalize p, q and r
  always_ff @(posedge clk) begin
    if (en[7]) begin
      sec7_r <= sec6_r;
      v7_r   <= v6_r;
      p7_r   <= div_unit_max(pp6_r);
      q7_r   <= div_unit_max(qp6_r);
      r7_r   <= div_unit_max(rp6_r);
    end
  end

  // Stage 8: route p, q, r, v to channels by sector, times 255
  always_comb begin
    unique case (sec7_r)
      SEC_R_TO_Y: begin cr = v7_r; cg = r7_r; cb = p7_r; end
      SEC_Y_TO_G: begin cr = q7_r; cg = v7_r; cb = p7_r; end
      SEC_G_TO_C: begin cr = p7_r; cg = v7_r; cb = r7_r; end
      SEC_C_TO_B: begin cr = p7_r; cg = q7_r; cb = v7_r; end
      SEC_B_TO_M: begin cr = r7_r; cg = p7_r; cb = v7_r; end
      SEC_M_TO_R: begin cr = v7_r; cg = p7_r; cb = q7_r; end
      default:    begin cr = v7_r; cg = p7_r; cb = q7_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      rx8_r <= {cr, 8'h00} - {8'h00, cr};
      gx8_r <= {cg, 8'h00} - {8'h00, cg};
      bx8_r <= {cb, 8'h00} - {8'h00, cb};
    end
  end

  // Stage 9: scale to 8 bits into the output register
  logic [15:0] red_q, green_q, blue_q;

  assign red_q   = div_unit_max({8'h00, rx8_r});
  assign green_q = div_unit_max({8'h00, gx8_r});
  assign blue_q  = div_unit_max({8'h00, bx8_r});

  always_ff @(posedge clk) begin
    if (en[9]) begin
      rgb9_r.red   <= red_q[7:0];
      rgb9_r.green <= green_q[7:0];
      rgb9_r.blue  <= blue_q[7:0];
    end
  end

  // Full middle stage held by backpressure
  assign mid_stall = vld_r[3] && !en[3];

  // An empty output register must open the whole pipeline
  `ASSERT_IMPLIES(a_empty_out_ready, clk, rst_n, !out_tvalid, in_tready, "input stalled")
  // An asserted out_tready must open the whole pipeline
  `ASSERT_IMPLIES(a_taken_out_ready, clk, rst_n, out_tready, in_tready, "input stalled")
  // A stalled full middle stage keeps its hue
  `ASSERT_NEXT(a_mid_hold, clk, rst_n, mid_stall, vld_r[3] && $stable(h3_r), "stage 3 lost data")

endmodule

`default_nettype wire

// ----- test/hsv_gradient_to_rgb_core_test.sv -----
`default_nettype none

module hsv_gradient_to_rgb_core_test;
  import hsvg2rgb_pkg::*;

  // Operation carried in tuser
  typedef enum logic {
    OP_DIRECT   = 1'b0,
    OP_GRADIENT = 1'b1
  } color_op_t;

  // Register indexes past the last register; writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam longint unsigned UNIT_ONE = 64'd65535;
  localparam longint unsigned FULL_TURN = 64'd65536;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_UNITS = 400000;
  localparam int BEATS_PER_SETTING = 110;

  typedef struct {
    color_op_t   op;
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] bri;
    logic [15:0] pos;
  } hsv_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // hue, saturation, brightness, position
  logic        in_tuser = 1'b0; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // red, green, blue
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // Gradient end points as the block should hold them
  logic [15:0] grad_reg [6];

  hsv_beat_t pending_beats [$];
  rgb_t      expected_rgb [$];
  hsv_beat_t beat_on_bus;
  rgb_t      rgb_want;
  rgb_t      rgb_got;
  int        beats_queued = 0;
  int        beats_accepted = 0;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  hsv_gradient_to_rgb_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Linear blend of two unit fractions at position t
  function automatic longint unsigned blend_unit(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned t);
    return ((UNIT_ONE - t) * a + t * b) / UNIT_ONE;
  endfunction

  function automatic logic [7:0] scale_to_byte(input longint unsigned c);
    return 8'((c * 255) / UNIT_ONE);
  endfunction

  // Expected RGB for one beat, six-sector scheme
  function automatic rgb_t convert_hsv(input hsv_beat_t b);
    longint unsigned h, s, v, t, x, f, p, q, r, cr, cg, cb;
    logic [2:0] sector;
    rgb_t res;
    if (b.op == OP_DIRECT) begin
      h = b.hue;
      s = b.sat;
      v = b.bri;
    end else begin
      t = b.pos;
      h = blend_unit(grad_reg[REG_START_HUE], grad_reg[REG_END_HUE], t);
      s = blend_unit(grad_reg[REG_START_SAT], grad_reg[REG_END_SAT], t);
      v = blend_unit(grad_reg[REG_START_VAL], grad_reg[REG_END_VAL], t);
    end
    x = h * 6;
    sector = 3'(x >> 16);
    f = x & (FULL_TURN - 1);
    p = (v * (UNIT_ONE - s)) / UNIT_ONE;
    q = (v * (UNIT_ONE - ((s * f) >> 16))) / UNIT_ONE;
    r = (v * (UNIT_ONE - ((s * (FULL_TURN - f)) >> 16))) / UNIT_ONE;
    case (sector)
      SEC_R_TO_Y: begin cr = v; cg = r; cb = p; end
      SEC_Y_TO_G: begin cr = q; cg = v; cb = p; end
      SEC_G_TO_C: begin cr = p; cg = v; cb = r; end
      SEC_C_TO_B: begin cr = p; cg = q; cb = v; end
      SEC_B_TO_M: begin cr = r; cg = p; cb = v; end
      default:    begin cr = v; cg = p; cb = q; end
    endcase
    res.red   = scale_to_byte(cr);
    res.green = scale_to_byte(cg);
    res.blue  = scale_to_byte(cb);
    return res;
  endfunction

  // Random word that lands on the extremes now and then
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_beat(input color_op_t op, input logic [15:0] hue,
                           input logic [15:0] sat, input logic [15:0] bri,
                           input logic [15:0] pos);
    hsv_beat_t b;
    b.op  = op;
    b.hue = hue;
    b.sat = sat;
    b.bri = bri;
    b.pos = pos;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Hold until every queued beat is in and every result is out
  task automatic wait_drain();
    while (beats_accepted != beats_queued || expected_rgb.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_END_VAL)
      grad_reg[idx] = val;
  endtask

  task automatic load_gradient(input logic [15:0] sh, input logic [15:0] ss,
                               input logic [15:0] sv, input logic [15:0] eh,
                               input logic [15:0] es, input logic [15:0] ev);
    wait_drain();
    write_reg(REG_START_HUE, sh);
    write_reg(REG_START_SAT, ss);
    write_reg(REG_START_VAL, sv);
    write_reg(REG_END_HUE, eh);
    write_reg(REG_END_SAT, es);
    write_reg(REG_END_VAL, ev);
  endtask

  // Driver: present the next pending beat, predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rgb.push_back(convert_hsv(beat_on_bus));
        beats_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = pending_beats.pop_front();
          in_tdata  <= {beat_on_bus.pos, beat_on_bus.bri, beat_on_bus.sat, beat_on_bus.hue};
          in_tuser  <= beat_on_bus.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rgb_got = out_tdata;
        if (expected_rgb.size() == 0) begin
          $error("RGB beat %h with no prediction waiting", out_tdata);
          error_count++;
        end else begin
          rgb_want = expected_rgb.pop_front();
          if (rgb_got.red !== rgb_want.red) begin
            $error("red: expected %0d, got %0d", rgb_want.red, rgb_got.red);
            error_count++;
          end
          if (rgb_got.green !== rgb_want.green) begin
            $error("green: expected %0d, got %0d", rgb_want.green, rgb_got.green);
            error_count++;
          end
          if (rgb_got.blue !== rgb_want.blue) begin
            $error("blue: expected %0d, got %0d", rgb_want.blue, rgb_got.blue);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    int mode;
    int setting;
    int k;
    logic [15:0] sh;
    logic [15:0] eh;
    for (k = 0; k < 6; k++)
      grad_reg[k] = 16'h0000;
    send_idle_pct = 32;
    recv_idle_pct = 71;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Gradient from reset values gives black
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'h0000);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'hFFFF);
    wait_drain();
    // Writes past the last register must not land anywhere
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hA5A5);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'h8000);

    // Field extremes and gray
    push_beat(OP_DIRECT, 16'h0000, 16'h0000, 16'h0000, pick_word());
    push_beat(OP_DIRECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'h1234, 16'h0000, 16'hFFFF, pick_word());

    // Both sides of each sector boundary at full saturation
    push_beat(OP_DIRECT, 16'd0,     16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd10922, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd10923, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd21845, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd21846, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd32767, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd32768, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd43690, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd43691, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd54613, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd54614, 16'hFFFF, 16'hFFFF, pick_word());
    push_beat(OP_DIRECT, 16'd65535, 16'hFFFF, 16'hFFFF, pick_word());

    // Full-range hue sweep, then all-ones end points
    load_gradient(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'h0000);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'h8000);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'hFFFF);
    load_gradient(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'h4000);
    push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), 16'hFFFF);

    // Random part: three idle patterns, several gradient settings each
    for (mode = 0; mode < 3; mode++) begin
      for (setting = 0; setting < 4; setting++) begin
        case (setting)
          0: load_gradient(pick_word(), pick_word(), pick_word(),
                           pick_word(), pick_word(), pick_word());
          1: load_gradient(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          2: load_gradient(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
          default: begin
            // Start hue near the top, end near the bottom: a long sweep down
            sh = 16'(16'hF000 + $urandom_range(16'h0FFF));
            eh = 16'($urandom_range(16'h0FFF));
            load_gradient(sh, pick_word(), pick_word(), eh, pick_word(), pick_word());
          end
        endcase
        case (mode)
          0: begin send_idle_pct = 32; recv_idle_pct = 71; end
          1: begin send_idle_pct = 71; recv_idle_pct = 32; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        for (k = 0; k < BEATS_PER_SETTING; k++) begin
          if ($urandom_range(1) == 0)
            push_beat(OP_DIRECT, pick_word(), pick_word(), pick_word(), pick_word());
          else
            push_beat(OP_GRADIENT, pick_word(), pick_word(), pick_word(), pick_word());
        end
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rgb.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_UNITS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ----- hsv_gradient_to_rgb_core.f -----
+incdir+hdl
hdl/hsvg2rgb_pkg.sv
hdl/hsv_gradient_to_rgb_core.sv
test/hsv_gradient_to_rgb_core_test.sv
